// ===== hdl/mtfr_pkg.sv =====
// Shared constants and types for the move-to-front rank unit.
`default_nettype none
package mtfr_pkg;

    localparam int MAX_ITEMS = 256;
    localparam int ITEM_W    = $clog2(MAX_ITEMS + 1);
    localparam int POS_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = 9;
    localparam int ABOVE_W   = 8;
    localparam int ID_W      = 9;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 8;

    localparam logic ACT_QUERY   = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIND,
        ST_MOVE
    } t_state;

    // Broadcast to every cell of the row.
    typedef struct packed {
        logic              restart;
        logic              move;
        logic [ITEM_W-1:0] query_id;
        logic [POS_W-1:0]  pos;
    } t_cell_ctrl;

endpackage
`default_nettype wire

// ===== hdl/mtfr_cell.sv =====
// One stack slot: holds an item number, matches it, takes its upper neighbor on a move.
`default_nettype none
module mtfr_cell (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [mtfr_pkg::POS_W-1:0] i_index,
    input  wire mtfr_pkg::t_cell_ctrl       i_ctrl,
    input  wire logic [mtfr_pkg::ITEM_W-1:0] i_prev_item,
    output logic [mtfr_pkg::ITEM_W-1:0]     o_item,
    output logic                            o_hit
);

    logic [mtfr_pkg::ITEM_W-1:0] r_item;
    logic [mtfr_pkg::ITEM_W-1:0] n_item;
    logic                        w_shift;

    // Slots from the top down to the hit slot move down by one.
    assign w_shift = i_ctrl.move && (i_index <= i_ctrl.pos);
    assign o_hit   = (r_item == i_ctrl.query_id);
    assign o_item  = r_item;

    always_comb begin
        n_item = r_item;
        if (i_ctrl.restart) begin
            n_item = mtfr_pkg::ITEM_W'(i_index) + mtfr_pkg::ITEM_W'(1);
        end else if (w_shift) begin
            n_item = i_prev_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item <= mtfr_pkg::ITEM_W'(i_index) + mtfr_pkg::ITEM_W'(1);
        end else begin
            r_item <= n_item;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/mtfr_chain.sv =====
// Row of stack cells with a one-hot to position encoder over their match flags.
`default_nettype none
module mtfr_chain (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire mtfr_pkg::t_cell_ctrl       i_ctrl,
    output logic [mtfr_pkg::POS_W-1:0]      o_pos
);

    logic [mtfr_pkg::ITEM_W-1:0] w_item [mtfr_pkg::MAX_ITEMS];
    logic [mtfr_pkg::MAX_ITEMS-1:0] w_hit;

    for (genvar g = 0; g < mtfr_pkg::MAX_ITEMS; g++) begin : g_cell
        logic [mtfr_pkg::ITEM_W-1:0] w_prev;
        if (g == 0) begin : g_top
            assign w_prev = i_ctrl.query_id;
        end else begin : g_below
            assign w_prev = w_item[g-1];
        end
        mtfr_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_index     (mtfr_pkg::POS_W'(g)),
            .i_ctrl      (i_ctrl),
            .i_prev_item (w_prev),
            .o_item      (w_item[g]),
            .o_hit       (w_hit[g])
        );
    end

    // Every item sits in exactly one slot, so the hits are one-hot: OR the indexes.
    always_comb begin
        o_pos = '0;
        for (int p = 0; p < mtfr_pkg::MAX_ITEMS; p++) begin
            if (w_hit[p]) begin
                o_pos = o_pos | mtfr_pkg::POS_W'(p);
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/move_to_front_rank_unit.sv =====
// Top level of the move-to-front rank unit: handshakes, sequencer and result register.
//
// Usage:
//   Slave stream: tuser = action (0 query, 1 restart), tdata = item_id in
//   bits [8:0], upper bits zero. Master stream: tdata = items_above [7:0],
//   tuser = bad_item. Config channel writes item_count (9 bits); it is
//   always ready and takes effect for the next query.
//   A query runs through the steps accept, search (all cells compare the id and
//   the one-hot hit is encoded to a position), then move (cells from the
//   top to the hit slot take their upper neighbor, the top takes the id)
//   while the result is loaded. One item is in work at a time, so a new
//   item is taken only once the last query has left the move step; a restart
//   is taken while idle and gives no result. Out-of-range ids give bad_item
//   with a zero count and leave the order as it is.
//   Reset (synchronous, active low) sets item_count to 256 and the stack to
//   item 1 on top through item 256 at the bottom.
//   If the receiver stalls, the result waits in the output register and
//   the next query holds in the move step until the register frees up.
`default_nettype none
module move_to_front_rank_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [mtfr_pkg::S_DATA_W-1:0] i_s_axis_tdata,  // item_id [8:0], zero pad
    input  wire logic                          i_s_axis_tuser,  // action
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output logic [mtfr_pkg::M_DATA_W-1:0]      o_m_axis_tdata,  // items_above [7:0]
    output logic                               o_m_axis_tuser,  // bad_item
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [mtfr_pkg::CNT_W-1:0]    i_cfg_data
);

    mtfr_pkg::t_state r_state, n_state;

    logic [mtfr_pkg::CNT_W-1:0]  r_count;
    logic [mtfr_pkg::ITEM_W-1:0] r_id;
    logic                        r_bad;
    logic [mtfr_pkg::POS_W-1:0]  r_pos;
    logic                        r_m_valid;
    logic [mtfr_pkg::ABOVE_W-1:0] r_m_above;
    logic                        r_m_bad;

    logic                        w_accept;
    logic                        w_slot_free;
    logic                        w_push;
    logic                        w_load_pos;
    logic [mtfr_pkg::ID_W-1:0]   w_id;
    logic [mtfr_pkg::CNT_W-1:0]  w_eff_count;
    logic                        w_bad;
    logic [mtfr_pkg::POS_W-1:0]  w_pos;
    mtfr_pkg::t_cell_ctrl        w_ctrl;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_slot_free = !r_m_valid || i_m_axis_tready;
    assign w_id        = i_s_axis_tdata[mtfr_pkg::ID_W-1:0];

    assign w_eff_count = (r_count > mtfr_pkg::CNT_W'(mtfr_pkg::MAX_ITEMS))
                       ? mtfr_pkg::CNT_W'(mtfr_pkg::MAX_ITEMS) : r_count;
    assign w_bad = (w_id == '0) || (mtfr_pkg::CNT_W'(w_id) > w_eff_count);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mtfr_pkg::ST_IDLE: begin
                if (w_accept && (i_s_axis_tuser == mtfr_pkg::ACT_QUERY)) begin
                    n_state = mtfr_pkg::ST_FIND;
                end
            end
            mtfr_pkg::ST_FIND: begin
                n_state = mtfr_pkg::ST_MOVE;
            end
            mtfr_pkg::ST_MOVE: begin
                if (w_slot_free) begin
                    n_state = mtfr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mtfr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_axis_tready = 1'b0;
        w_load_pos      = 1'b0;
        w_push          = 1'b0;
        w_ctrl.restart  = 1'b0;
        w_ctrl.move     = 1'b0;
        w_ctrl.query_id = r_id;
        w_ctrl.pos      = r_pos;
        unique case (r_state)
            mtfr_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                // Ready is high here, so valid alone marks the transfer.
                w_ctrl.restart  = i_s_axis_tvalid
                                  && (i_s_axis_tuser == mtfr_pkg::ACT_RESTART);
            end
            mtfr_pkg::ST_FIND: begin
                w_load_pos = 1'b1;
            end
            mtfr_pkg::ST_MOVE: begin
                w_push      = w_slot_free;
                w_ctrl.move = w_slot_free && !r_bad;
            end
            default: begin
                o_s_axis_tready = 1'b0;
            end
        endcase
    end

    mtfr_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .o_pos   (w_pos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mtfr_pkg::ST_IDLE;
            r_count   <= mtfr_pkg::CNT_W'(mtfr_pkg::MAX_ITEMS);
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_count <= i_cfg_data;
            end
            if (w_push) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Payload: hold the query, latch the hit position, load the result.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_id  <= mtfr_pkg::ITEM_W'(w_id);
            r_bad <= w_bad;
        end
        if (w_load_pos) begin
            r_pos <= w_pos;
        end
        if (w_push) begin
            r_m_above <= r_bad ? '0 : mtfr_pkg::ABOVE_W'(r_pos);
            r_m_bad   <= r_bad;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_above;
    assign o_m_axis_tuser  = r_m_bad;

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// Testbench for the move-to-front rank unit: directed table, random phases, self-checking.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400_000;
    localparam int SEG_ITEMS     = 120;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 6;
    localparam int MAX_PRINTED   = 20;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind                     kind;
        logic                          action;
        logic [mtfr_pkg::ID_W-1:0]     value;   // item id, or the new count
        logic                          typed;
        logic [mtfr_pkg::ABOVE_W-1:0]  above;
        logic                          bad;
    } t_stim_row;

    typedef struct packed {
        logic [mtfr_pkg::ABOVE_W-1:0] above;
        logic                         bad;
    } t_rank_result;

    localparam int DIR_ROWS = 28;

    logic                            i_clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic [mtfr_pkg::S_DATA_W-1:0]   s_tdata = '0;
    logic                            s_tuser = mtfr_pkg::ACT_QUERY;
    logic                            m_tready = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic [mtfr_pkg::CNT_W-1:0]      cfg_data = '0;
    logic                            hold_req = 1'b0;
    logic                            hold_on = 1'b0;
    int                              r_stall_pct = 0;

    wire                             o_s_axis_tready;
    wire                             o_m_axis_tvalid;
    wire [mtfr_pkg::M_DATA_W-1:0]    o_m_axis_tdata;
    wire                             o_m_axis_tuser;
    wire                             o_cfg_ready;

    // predictor state
    logic [mtfr_pkg::ITEM_W-1:0]     stack_items [mtfr_pkg::MAX_ITEMS];
    logic [mtfr_pkg::CNT_W-1:0]      item_limit;
    t_rank_result                    pending_ranks [$];

    t_stim_row             dir_rows [DIR_ROWS];
    int                    s_idle_pct = 0;
    int                    err_count = 0;
    int                    items_sent = 0;
    int                    results_checked = 0;
    int                    bad_seen = 0;
    int                    restarts_sent = 0;
    int                    cfg_writes = 0;
    int                    cycle_count = 0;

    move_to_front_rank_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    task automatic note_mismatch(input string msg);
        if (err_count < MAX_PRINTED) begin
            $display("MISMATCH @%0t: %s", $realtime, msg);
        end
        err_count++;
    endtask

    task automatic restart_stack();
        for (int p = 0; p < mtfr_pkg::MAX_ITEMS; p++) begin
            stack_items[p] = mtfr_pkg::ITEM_W'(p + 1);
        end
    endtask

    // Rank the item, then move it to the top of the stack; a restart resets the stack and an out-of-range id is bad.
    task automatic rank_and_move(input logic act, input logic [mtfr_pkg::ID_W-1:0] id,
                                 output bit has_res, output t_rank_result res);
        int eff;
        int hit;
        has_res = 1'b0;
        res = '0;
        if (act == mtfr_pkg::ACT_RESTART) begin
            restart_stack();
            return;
        end
        eff = (int'(item_limit) > mtfr_pkg::MAX_ITEMS) ? mtfr_pkg::MAX_ITEMS
                                                      : int'(item_limit);
        has_res = 1'b1;
        if (id < 1 || int'(id) > eff) begin
            res.bad = 1'b1;
            return;
        end
        hit = 0;
        while (hit < mtfr_pkg::MAX_ITEMS - 1 && stack_items[hit] != mtfr_pkg::ITEM_W'(id))
            hit++;
        for (int p = hit; p > 0; p--) begin
            stack_items[p] = stack_items[p-1];
        end
        stack_items[0] = mtfr_pkg::ITEM_W'(id);
        res.above = mtfr_pkg::ABOVE_W'(hit);
    endtask

    task automatic send_item(input logic act, input logic [mtfr_pkg::ID_W-1:0] id,
                             input bit typed, input t_rank_result typed_res);
        bit           has_res;
        t_rank_result res;
        s_tvalid <= 1'b1;
        s_tdata  <= mtfr_pkg::S_DATA_W'(id);
        s_tuser  <= act;
        do @(posedge i_clk); while (!o_s_axis_tready);
        rank_and_move(act, id, has_res, res);
        if (has_res) pending_ranks.push_back(typed ? typed_res : res);
        items_sent++;
        if (act == mtfr_pkg::ACT_RESTART) restarts_sent++;
        if ($urandom_range(99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < s_idle_pct);
        end
    endtask

    // Hold input until every result is back and the unit has settled.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_ranks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [mtfr_pkg::CNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid  <= 1'b0;
        item_limit = value;
        cfg_writes++;
        @(posedge i_clk);
    endtask

    // Result checker and receiver stall.
    initial begin
        t_rank_result want;
        forever begin
            @(posedge i_clk);
            if (rst_n && o_m_axis_tvalid && m_tready) begin
                if (pending_ranks.size() == 0) begin
                    note_mismatch($sformatf("unexpected result above=%0d bad=%0b",
                                            o_m_axis_tdata, o_m_axis_tuser));
                end else begin
                    want = pending_ranks.pop_front();
                    if (o_m_axis_tdata !== want.above)
                        note_mismatch($sformatf("items_above %0d, expected %0d",
                                                o_m_axis_tdata, want.above));
                    if (o_m_axis_tuser !== want.bad)
                        note_mismatch($sformatf("bad_item %0b, expected %0b",
                                                o_m_axis_tuser, want.bad));
                    if (want.bad) bad_seen++;
                    results_checked++;
                end
            end
            m_tready <= !hold_on && ($urandom_range(99) >= r_stall_pct);
        end
    end

    // Long receiver hold-off, counted here; a toggle of hold_req starts one.
    initial begin
        logic hold_seen;
        hold_seen = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_on  <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_on  <= 1'b0;
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles, %0d results outstanding",
                         cycle_count, pending_ranks.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        int                          eff;
        int                          pick;
        logic                        act;
        logic [mtfr_pkg::ID_W-1:0]   id;
        logic [mtfr_pkg::CNT_W-1:0]  new_count;

        dir_rows = '{
            '{ROW_ITEM, mtfr_pkg::ACT_QUERY,   9'd1,   1'b1, 8'd0,   1'b0},
            '{ROW_ITEM, mtfr_pkg::ACT_QUERY,   9'd256, 1'b1, 8'd255, 1'b0},
            '{ROW_ITEM, mtfr_pkg::ACT_QUERY,   9'd0,   1'b1, 8'd0,   1'b1},
            '{ROW_ITEM, mtfr_pkg::ACT_QUERY,   9'd257, 1'b1, 8'd0,   1'b1},
            '{ROW_ITEM, mtfr_pkg::ACT_QUERY,   9'd511, 1'b1, 8'd0,   1'b1},
            '{ROW_ITEM, mtfr_pkg::ACT_QUERY,   9'd256, 1'b1, 8'd0,   1'b0},
            '{ROW_ITEM, mtfr_pkg::ACT_QUERY,   9'd170, 1'b0, 8'd0,   1'b0},
            '{ROW_ITEM, mtfr_pkg::ACT_QUERY,   9'd341, 1'b1, 8'd0,   1'b1},
            '{ROW_ITEM, mtfr_pkg::ACT_QUERY,   9'd85,  1'b0, 8'd0,   1'b0},
            '{ROW_ITEM, mtfr_pkg::ACT_RESTART, 9'd0,   1'b0, 8'd0,   1'b0},
            '{ROW_ITEM, mtfr_pkg::ACT_QUERY,   9'd256, 1'b1, 8'd255, 1'b0},
            // count of one: only item 1 is valid
            '{ROW_CFG,  mtfr_pkg::ACT_QUERY,   9'd1,   1'b0, 8'd0,   1'b0},
            '{ROW_ITEM, mtfr_pkg::ACT_QUERY,   9'd1,   1'b0, 8'd0,   1'b0},
            '{ROW_ITEM, mtfr_pkg::ACT_QUERY,   9'd2,   1'b1, 8'd0,   1'b1},
            // count of zero: everything is a bad item
            '{ROW_CFG,  mtfr_pkg::ACT_QUERY,   9'd0,   1'b0, 8'd0,   1'b0},
            '{ROW_ITEM, mtfr_pkg::ACT_QUERY,   9'd1,   1'b1, 8'd0,   1'b1},
            // count above the stack size clamps to the stack size
            '{ROW_CFG,  mtfr_pkg::ACT_QUERY,   9'd511, 1'b0, 8'd0,   1'b0},
            '{ROW_ITEM, mtfr_pkg::ACT_QUERY,   9'd256, 1'b0, 8'd0,   1'b0},
            '{ROW_ITEM, mtfr_pkg::ACT_QUERY,   9'd300, 1'b1, 8'd0,   1'b1},
            '{ROW_ITEM, mtfr_pkg::ACT_QUERY,   9'd200, 1'b0, 8'd0,   1'b0},
            // lowered count: items moved up earlier still count above
            '{ROW_CFG,  mtfr_pkg::ACT_QUERY,   9'd4,   1'b0, 8'd0,   1'b0},
            '{ROW_ITEM, mtfr_pkg::ACT_QUERY,   9'd4,   1'b0, 8'd0,   1'b0},
            '{ROW_ITEM, mtfr_pkg::ACT_QUERY,   9'd5,   1'b1, 8'd0,   1'b1},
            '{ROW_ITEM, mtfr_pkg::ACT_RESTART, 9'd0,   1'b0, 8'd0,   1'b0},
            '{ROW_ITEM, mtfr_pkg::ACT_QUERY,   9'd4,   1'b1, 8'd3,   1'b0},
            '{ROW_CFG,  mtfr_pkg::ACT_QUERY,   9'd256, 1'b0, 8'd0,   1'b0},
            '{ROW_ITEM, mtfr_pkg::ACT_QUERY,   9'd255, 1'b1, 8'd254, 1'b0},
            '{ROW_ITEM, mtfr_pkg::ACT_QUERY,   9'd255, 1'b1, 8'd0,   1'b0}
        };

        item_limit = mtfr_pkg::CNT_W'(mtfr_pkg::MAX_ITEMS);
        restart_stack();
        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                wait_idle();
                write_count(dir_rows[i].value[mtfr_pkg::CNT_W-1:0]);
            end else begin
                send_item(dir_rows[i].action, dir_rows[i].value, dir_rows[i].typed,
                          '{above: dir_rows[i].above, bad: dir_rows[i].bad});
            end
        end

        // phases: no idling, sender idle, receiver stall, both
        for (int phase = 0; phase < 4; phase++) begin
            wait_idle();
            s_idle_pct  = (phase == 1) ? 59 : (phase == 3) ? 19 : 0;
            r_stall_pct <= (phase == 2) ? 59 : (phase == 3) ? 19 : 0;
            for (int seg = 0; seg < 3; seg++) begin
                wait_idle();
                pick = $urandom_range(9);
                case (pick)
                    0: new_count = mtfr_pkg::CNT_W'(1);
                    1: new_count = mtfr_pkg::CNT_W'(mtfr_pkg::MAX_ITEMS);
                    2: new_count = '1;
                    6, 7: new_count = mtfr_pkg::CNT_W'($urandom_range(2, 16));
                    8: new_count = mtfr_pkg::CNT_W'($urandom_range(mtfr_pkg::MAX_ITEMS + 1,
                                                                   511));
                    9: new_count = '0;
                    default: new_count = mtfr_pkg::CNT_W'($urandom_range(1,
                                                                         mtfr_pkg::MAX_ITEMS));
                endcase
                write_count(new_count);
                if (phase == 0 && seg == 1) hold_req <= !hold_req;
                eff = (int'(item_limit) > mtfr_pkg::MAX_ITEMS) ? mtfr_pkg::MAX_ITEMS
                                                              : int'(item_limit);
                for (int n = 0; n < SEG_ITEMS; n++) begin
                    pick = $urandom_range(99);
                    act = mtfr_pkg::ACT_QUERY;
                    if (pick < 3) begin
                        act = mtfr_pkg::ACT_RESTART;
                        id  = mtfr_pkg::ID_W'($urandom_range(511));
                    end else if (pick < 11 || eff == 0) begin
                        id = ($urandom_range(3) == 0) ? '0
                             : mtfr_pkg::ID_W'($urandom_range(eff + 1, 511));
                    end else if ($urandom_range(2) == 0) begin
                        // favor the low item ids, 1 up to 8 (or up to the count)
                        id = mtfr_pkg::ID_W'($urandom_range(1, (eff < 8) ? eff : 8));
                    end else begin
                        id = mtfr_pkg::ID_W'($urandom_range(1, eff));
                    end
                    send_item(act, id, 1'b0, '0);
                end
            end
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        $display("Covered %0d items (%0d restarts) over %0d count settings and four idle mixes,",
                 items_sent, restarts_sent, cfg_writes);
        $display("checked %0d results, %0d of them bad items, with a long receiver hold-off.",
                 results_checked, bad_seen);
        if (err_count == 0 && pending_ranks.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
hdl/mtfr_pkg.sv
hdl/mtfr_cell.sv
hdl/mtfr_chain.sv
hdl/move_to_front_rank_unit.sv
bench/tb.sv
